// ===== rtl/akst_pkg.sv =====
// Types, codes and the update program of the altitude Kalman stage tracker.
// No dependencies; every other file but akst_ram imports this package.
package akst_pkg;

  localparam int WIDE_W  = 48;
  localparam int OPND_W  = 50;
  localparam int RF_DEPTH = 64;
  localparam int RF_AW   = 6;
  localparam int PROG_LEN = 184;
  localparam int PC_W    = 8;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [15:0] STEP_TIME_RST = 16'd655;
  localparam logic [30:0] GRAVITY_RST   = 31'd642908;
  localparam logic [30:0] THRESH_RST    = 31'd1310720;
  localparam logic [30:0] Q_ALT_RST     = 31'd6554;
  localparam logic [30:0] Q_VEL_RST     = 31'd655;
  localparam logic [30:0] Q_ACC_RST     = 31'd655;
  localparam logic [30:0] Q_JERK_RST    = 31'd66;
  localparam logic [30:0] OBS_NOISE_RST = 31'd6553600;

  typedef enum logic [3:0] {
    CFG_STEP_TIME = 4'd0,
    CFG_GRAVITY   = 4'd1,
    CFG_THRESHOLD = 4'd2,
    CFG_Q_ALT     = 4'd3,
    CFG_Q_VEL     = 4'd4,
    CFG_Q_ACC     = 4'd5,
    CFG_Q_JERK    = 4'd6,
    CFG_OBS_NOISE = 4'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STG_GROUND  = 2'd0,
    STG_BURNOUT = 2'd1,
    STG_APOGEE  = 2'd2
  } stage_e;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EST = 3'd4,
    OP_END = 3'd5
  } uop_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_FETCH = 3'd1,
    ST_ISSUE = 3'd2,
    ST_WAIT  = 3'd3,
    ST_DONE  = 3'd4
  } ctrl_state_e;

  // operand codes: below 64 a register file entry, 64 and above a special source
  localparam logic [6:0] SRC_ZERO = 7'd64;
  localparam logic [6:0] SRC_DT   = 7'd65;
  localparam logic [6:0] SRC_RN   = 7'd66;
  localparam logic [6:0] SRC_NEGG = 7'd67;
  localparam logic [6:0] SRC_QA   = 7'd68;
  localparam logic [6:0] SRC_QV   = 7'd69;
  localparam logic [6:0] SRC_QC   = 7'd70;
  localparam logic [6:0] SRC_QJ   = 7'd71;
  localparam logic [6:0] SRC_MEAS = 7'd72;
  localparam logic [6:0] SRC_X0   = 7'd73;
  localparam logic [6:0] SRC_X1   = 7'd74;
  localparam logic [6:0] SRC_X2   = 7'd75;
  localparam logic [6:0] SRC_X3   = 7'd76;
  localparam logic [6:0] SRC_ACC  = 7'd77;

  localparam int A_P   = 0;
  localparam int A_PU  = 16;
  localparam int A_S00 = 32;
  localparam int A_S01 = 33;
  localparam int A_S10 = 34;
  localparam int A_S11 = 35;
  localparam int A_DET = 36;
  localparam int A_T0  = 37;
  localparam int A_T1  = 38;
  localparam int A_Y0  = 39;
  localparam int A_Y1  = 40;
  localparam int A_XU  = 41;
  localparam int A_K   = 45;
  localparam int A_SCR = 54;

  typedef struct packed {
    uop_e       op;
    logic [6:0] a;
    logic       ga;
    logic [6:0] b;
    logic       gb;
    logic [5:0] dst;
  } uop_t;

  typedef uop_t [PROG_LEN-1:0] prog_t;

  typedef struct packed {
    logic load_start;
    logic begin_step;
    logic fetch;
    logic issue;
    logic load_out;
    uop_t uop;
  } akst_cmd_t;

  typedef struct packed {
    logic exec_done;
  } akst_sts_t;

  typedef struct packed {
    logic              kind;
    logic signed [31:0] altitude;
    logic signed [31:0] start_velocity;
  } akst_in_t;

  typedef struct packed {
    logic signed [31:0] est_altitude;
    logic signed [31:0] est_velocity;
    logic signed [31:0] est_acceleration;
    logic signed [31:0] est_jerk;
    logic [1:0]         stage;
  } akst_out_t;

  function automatic uop_t mk(uop_e op, int a, logic ga, int b, logic gb, int d);
    uop_t u;
    u.op  = op;
    u.a   = 7'(a);
    u.ga  = ga;
    u.b   = 7'(b);
    u.gb  = gb;
    u.dst = 6'(d);
    return u;
  endfunction

  function automatic prog_t build_prog();
    prog_t p;
    int    n;
    int    r;
    int    c;
    int    e;
    p = '0;
    n = 0;
    // innovation covariance and its determinant
    p[n] = mk(OP_ADD, A_P + 0, 1'b0, SRC_RN, 1'b0, A_S00);    n++;
    p[n] = mk(OP_ADD, A_P + 2, 1'b1, SRC_ZERO, 1'b0, A_S01);  n++;
    p[n] = mk(OP_ADD, A_P + 8, 1'b1, SRC_ZERO, 1'b0, A_S10);  n++;
    p[n] = mk(OP_ADD, A_P + 10, 1'b1, SRC_RN, 1'b0, A_S11);   n++;
    p[n] = mk(OP_MUL, A_S00, 1'b0, A_S11, 1'b0, A_T0);        n++;
    p[n] = mk(OP_MUL, A_S01, 1'b0, A_S10, 1'b0, A_T1);        n++;
    p[n] = mk(OP_SUB, A_T0, 1'b0, A_T1, 1'b0, A_DET);         n++;
    // gain by adjugate
    for (r = 0; r < 4; r++) begin
      p[n] = mk(OP_MUL, A_P + 4*r, 1'b0, A_S11, 1'b0, A_T0);     n++;
      p[n] = mk(OP_MUL, A_P + 4*r + 2, 1'b1, A_S10, 1'b0, A_T1); n++;
      p[n] = mk(OP_SUB, A_T0, 1'b0, A_T1, 1'b0, A_T0);           n++;
      p[n] = mk(OP_DIV, A_T0, 1'b0, A_DET, 1'b0, A_K + 2*r);     n++;
      p[n] = mk(OP_MUL, A_P + 4*r + 2, 1'b1, A_S00, 1'b0, A_T0); n++;
      p[n] = mk(OP_MUL, A_P + 4*r, 1'b0, A_S01, 1'b0, A_T1);     n++;
      p[n] = mk(OP_SUB, A_T0, 1'b0, A_T1, 1'b0, A_T0);           n++;
      p[n] = mk(OP_DIV, A_T0, 1'b0, A_DET, 1'b0, A_K + 2*r + 1); n++;
    end
    // residuals
    p[n] = mk(OP_SUB, SRC_MEAS, 1'b0, SRC_X0, 1'b0, A_Y0); n++;
    p[n] = mk(OP_SUB, SRC_NEGG, 1'b1, SRC_X2, 1'b1, A_Y1); n++;
    // state update
    for (r = 0; r < 4; r++) begin
      p[n] = mk(OP_MUL, A_K + 2*r, 1'b0, A_Y0, 1'b0, A_T0);       n++;
      p[n] = mk(OP_MUL, A_K + 2*r + 1, 1'b0, A_Y1, 1'b0, A_T1);   n++;
      p[n] = mk(OP_ADD, SRC_X0 + r, 1'b0, A_T0, 1'b0, A_SCR);     n++;
      p[n] = mk(OP_ADD, SRC_ACC, 1'b0, A_T1, 1'b0, A_XU + r);     n++;
    end
    // covariance update
    for (r = 0; r < 4; r++) begin
      for (c = 0; c < 4; c++) begin
        e = 4*r + c;
        p[n] = mk(OP_MUL, A_K + 2*r, 1'b0, A_P + c, 1'b0, A_T0);         n++;
        p[n] = mk(OP_MUL, A_K + 2*r + 1, 1'b0, A_P + 8 + c, 1'b0, A_T1); n++;
        p[n] = mk(OP_SUB, A_P + e, 1'b0, A_T0, 1'b0, A_SCR);             n++;
        p[n] = mk(OP_SUB, SRC_ACC, 1'b0, A_T1, 1'b0, A_PU + e);          n++;
      end
    end
    // state predict
    for (r = 0; r < 3; r++) begin
      p[n] = mk(OP_MUL, SRC_DT, 1'b0, A_XU + r + 1, 1'b0, A_T0); n++;
      p[n] = mk(OP_EST, A_XU + r, 1'b0, A_T0, 1'b0, r);          n++;
    end
    p[n] = mk(OP_EST, A_XU + 3, 1'b0, SRC_ZERO, 1'b0, 3); n++;
    // left product, rows in place
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 4; c++) begin
        e = 4*r + c;
        p[n] = mk(OP_MUL, SRC_DT, 1'b0, A_PU + e + 4, 1'b0, A_T0); n++;
        p[n] = mk(OP_ADD, A_PU + e, 1'b0, A_T0, 1'b0, A_PU + e);   n++;
      end
    end
    // right product and process noise
    for (r = 0; r < 4; r++) begin
      for (c = 0; c < 4; c++) begin
        e = 4*r + c;
        if (c < 3) begin
          p[n] = mk(OP_MUL, SRC_DT, 1'b0, A_PU + e + 1, 1'b0, A_T0); n++;
          if (r == c) begin
            p[n] = mk(OP_ADD, A_PU + e, 1'b0, A_T0, 1'b0, A_SCR);      n++;
            p[n] = mk(OP_ADD, A_SCR, 1'b0, SRC_QA + r, 1'b0, A_P + e); n++;
          end else begin
            p[n] = mk(OP_ADD, A_PU + e, 1'b0, A_T0, 1'b0, A_P + e); n++;
          end
        end else if (r == 3) begin
          p[n] = mk(OP_ADD, A_PU + e, 1'b0, SRC_QJ, 1'b0, A_P + e); n++;
        end else begin
          p[n] = mk(OP_ADD, A_PU + e, 1'b0, SRC_ZERO, 1'b0, A_P + e); n++;
        end
      end
    end
    p[n] = mk(OP_END, SRC_ZERO, 1'b0, SRC_ZERO, 1'b0, 0);
    return p;
  endfunction

endpackage

// ===== rtl/akst_ram.sv =====
// Generic two-read, one-write RAM with registered read data.
// No dependencies.
module akst_ram #(
  parameter int Width = 48,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/akst_muldiv.sv =====
// Shared multi-cycle Q32.16 multiplier (24x24 partial products) and
// restoring divider with saturation. Depends on akst_pkg.
module akst_muldiv import akst_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     is_div_i,
  input  logic signed [WIDE_W-1:0] a_i,
  input  logic signed [WIDE_W-1:0] b_i,
  output logic                     done_o,
  output logic signed [WIDE_W-1:0] res_o
);

  localparam logic [63:0] POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAX = 64'h0000_8000_0000_0000;

  logic              busy_q;
  logic              div_q;
  logic [6:0]        cnt_q;
  logic              neg_q;
  logic              big_q;
  logic              zero_q;
  logic [WIDE_W-1:0] ma_q;
  logic [WIDE_W-1:0] mb_q;
  logic [47:0]       pp_q;
  logic [63:0]       acc_q;
  logic [47:0]       rem_q;
  logic [WIDE_W-1:0] ma;
  logic [WIDE_W-1:0] mb;
  logic [23:0]       mx;
  logic [23:0]       my;
  logic [48:0]       trial;
  logic              last;

  assign ma = a_i[WIDE_W-1] ? WIDE_W'(-a_i) : WIDE_W'(a_i);
  assign mb = b_i[WIDE_W-1] ? WIDE_W'(-b_i) : WIDE_W'(b_i);

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    begin mx = ma_q[23:0];  my = mb_q[23:0];  end
      2'd1:    begin mx = ma_q[23:0];  my = mb_q[47:24]; end
      2'd2:    begin mx = ma_q[47:24]; my = mb_q[23:0];  end
      default: begin mx = ma_q[47:24]; my = mb_q[47:24]; end
    endcase
  end

  assign trial = {rem_q, acc_q[63]};
  assign last  = div_q ? (cnt_q == 7'd64) : (cnt_q == 7'd5);
  assign done_o = busy_q && last;

  always_comb begin
    if (zero_q) begin
      res_o = '0;
    end else if (neg_q) begin
      res_o = (big_q || acc_q > NEG_MAX) ? WIDE_W'(NEG_MAX) : WIDE_W'(-acc_q);
    end else begin
      res_o = (big_q || acc_q > POS_MAX) ? WIDE_W'(POS_MAX) : WIDE_W'(acc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      busy_q <= !last;
      cnt_q  <= cnt_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= is_div_i;
      neg_q  <= a_i[WIDE_W-1] ^ b_i[WIDE_W-1];
      ma_q   <= ma;
      mb_q   <= mb;
      big_q  <= 1'b0;
      zero_q <= is_div_i && (mb == '0);
      rem_q  <= '0;
      acc_q  <= is_div_i ? {ma, 16'd0} : '0;
    end else if (busy_q && !last) begin
      if (div_q) begin
        if (trial >= {1'b0, mb_q}) begin
          rem_q <= 48'(trial - {1'b0, mb_q});
          acc_q <= {acc_q[62:0], 1'b1};
        end else begin
          rem_q <= trial[47:0];
          acc_q <= {acc_q[62:0], 1'b0};
        end
      end else begin
        pp_q <= mx * my;
        case (cnt_q[2:0])
          3'd1:    acc_q <= acc_q + 64'(pp_q[47:16]);
          3'd2,
          3'd3:    acc_q <= acc_q + {8'd0, pp_q, 8'd0};
          3'd4: begin
            big_q <= pp_q > 48'h7FFF;
            acc_q <= acc_q + {pp_q[31:0], 32'd0};
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/akst_dp.sv =====
// Datapath: configuration, estimate and stage registers, register file,
// operand selection, adder and the shared multiply/divide unit.
// Depends on akst_pkg, akst_ram and akst_muldiv.
module akst_dp import akst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  akst_in_t    in_data_i,
  input  akst_cmd_t   cmd_i,
  output akst_sts_t   sts_o,
  output akst_out_t   out_data_o
);

  localparam logic signed [OPND_W-1:0] W_MAX = OPND_W'(48'sh7FFF_FFFF_FFFF);
  localparam logic signed [OPND_W-1:0] W_MIN = -W_MAX - OPND_W'(1);
  localparam logic signed [OPND_W-1:0] N_MAX = OPND_W'(32'sh7FFF_FFFF);
  localparam logic signed [OPND_W-1:0] N_MIN = -N_MAX - OPND_W'(1);

  logic [15:0]        step_time_q;
  logic [30:0]        gravity_q;
  logic [30:0]        thresh_q;
  logic [30:0]        q_alt_q;
  logic [30:0]        q_vel_q;
  logic [30:0]        q_acc_q;
  logic [30:0]        q_jerk_q;
  logic [30:0]        obs_noise_q;
  logic signed [31:0] est_q [4];
  logic signed [31:0] peak_q;
  logic signed [31:0] peak_d;
  stage_e             stage_q;
  stage_e             stage_d;
  logic               h_q;
  logic signed [31:0] meas_q;
  logic [RF_DEPTH-1:0] valid_q;
  logic signed [OPND_W-1:0] acc_q;

  logic [6:0]               code_a_q;
  logic [6:0]               code_b_q;
  logic                     ga_q;
  logic                     gb_q;
  logic signed [OPND_W-1:0] spa_q;
  logic signed [OPND_W-1:0] spb_q;
  logic                     vala_q;
  logic                     valb_q;
  uop_e                     op_q;
  logic [RF_AW-1:0]         dst_q;

  logic [WIDE_W-1:0]        rda;
  logic [WIDE_W-1:0]        rdb;
  logic signed [OPND_W-1:0] opa;
  logic signed [OPND_W-1:0] opb;
  logic signed [OPND_W-1:0] alu;
  logic signed [OPND_W-1:0] res;
  logic                     simple;
  logic                     done;
  logic                     md_done;
  logic signed [WIDE_W-1:0] md_res;
  logic signed [WIDE_W-1:0] wb_data;
  logic                     wb_en;

  function automatic logic signed [OPND_W-1:0] spec_val(logic [6:0] code);
    logic signed [OPND_W-1:0] v;
    v = '0;
    unique case (code)
      SRC_DT:   v = OPND_W'(step_time_q);
      SRC_RN:   v = OPND_W'(obs_noise_q);
      SRC_NEGG: v = -$signed(OPND_W'(gravity_q));
      SRC_QA:   v = OPND_W'(q_alt_q);
      SRC_QV:   v = OPND_W'(q_vel_q);
      SRC_QC:   v = OPND_W'(q_acc_q);
      SRC_QJ:   v = OPND_W'(q_jerk_q);
      SRC_MEAS: v = OPND_W'(meas_q);
      SRC_X0:   v = OPND_W'(est_q[0]);
      SRC_X1:   v = OPND_W'(est_q[1]);
      SRC_X2:   v = OPND_W'(est_q[2]);
      SRC_X3:   v = OPND_W'(est_q[3]);
      SRC_ACC:  v = acc_q;
      default:  v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [WIDE_W-1:0] sat_wide(logic signed [OPND_W-1:0] v);
    logic signed [OPND_W-1:0] s;
    s = (v > W_MAX) ? W_MAX : ((v < W_MIN) ? W_MIN : v);
    return s[WIDE_W-1:0];
  endfunction

  function automatic logic signed [31:0] sat_narrow(logic signed [OPND_W-1:0] v);
    logic signed [OPND_W-1:0] s;
    s = (v > N_MAX) ? N_MAX : ((v < N_MIN) ? N_MIN : v);
    return s[31:0];
  endfunction

  akst_ram #(
    .Width(WIDE_W),
    .Depth(RF_DEPTH)
  ) u_rf (
    .clk_i     (clk_i),
    .we_i      (wb_en),
    .waddr_i   (dst_q),
    .wdata_i   (wb_data),
    .raddr_a_i (cmd_i.uop.a[RF_AW-1:0]),
    .rdata_a_o (rda),
    .raddr_b_i (cmd_i.uop.b[RF_AW-1:0]),
    .rdata_b_o (rdb)
  );

  akst_muldiv u_md (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.issue && !simple),
    .is_div_i (op_q == OP_DIV),
    .a_i      (opa[WIDE_W-1:0]),
    .b_i      (opb[WIDE_W-1:0]),
    .done_o   (md_done),
    .res_o    (md_res)
  );

  always_comb begin
    opa = code_a_q[6] ? spa_q : (vala_q ? OPND_W'($signed(rda)) : '0);
    opb = code_b_q[6] ? spb_q : (valb_q ? OPND_W'($signed(rdb)) : '0);
    if (ga_q && !h_q) begin
      opa = '0;
    end
    if (gb_q && !h_q) begin
      opb = '0;
    end
  end

  assign simple  = (op_q == OP_ADD) || (op_q == OP_SUB) || (op_q == OP_EST);
  assign alu     = (op_q == OP_SUB) ? opa - opb : opa + opb;
  assign done    = (cmd_i.issue && simple) || md_done;
  assign res     = simple ? alu : OPND_W'(md_res);
  assign wb_data = sat_wide(res);
  assign wb_en   = done && (op_q != OP_EST);
  assign sts_o.exec_done = done;

  always_comb begin
    peak_d  = (est_q[2] > peak_q) ? est_q[2] : peak_q;
    stage_d = stage_q;
    unique case (stage_q)
      STG_GROUND: begin
        if ($signed(33'(peak_d)) > $signed({2'b00, thresh_q}) && est_q[3][31]) begin
          stage_d = STG_BURNOUT;
        end
      end
      STG_BURNOUT: begin
        if (est_q[1][31]) begin
          stage_d = STG_APOGEE;
        end
      end
      default: stage_d = stage_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q <= STEP_TIME_RST;
      gravity_q   <= GRAVITY_RST;
      thresh_q    <= THRESH_RST;
      q_alt_q     <= Q_ALT_RST;
      q_vel_q     <= Q_VEL_RST;
      q_acc_q     <= Q_ACC_RST;
      q_jerk_q    <= Q_JERK_RST;
      obs_noise_q <= OBS_NOISE_RST;
      est_q       <= '{default: '0};
      peak_q      <= '0;
      stage_q     <= STG_GROUND;
      h_q         <= 1'b0;
      valid_q     <= '0;
      acc_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_STEP_TIME: step_time_q <= cfg_data_i[15:0];
          CFG_GRAVITY:   gravity_q   <= cfg_data_i[30:0];
          CFG_THRESHOLD: thresh_q    <= cfg_data_i[30:0];
          CFG_Q_ALT:     q_alt_q     <= cfg_data_i[30:0];
          CFG_Q_VEL:     q_vel_q     <= cfg_data_i[30:0];
          CFG_Q_ACC:     q_acc_q     <= cfg_data_i[30:0];
          CFG_Q_JERK:    q_jerk_q    <= cfg_data_i[30:0];
          CFG_OBS_NOISE: obs_noise_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (cmd_i.load_start) begin
        est_q[0] <= in_data_i.altitude;
        est_q[1] <= in_data_i.start_velocity;
        est_q[2] <= '0;
        est_q[3] <= '0;
        peak_q   <= '0;
        stage_q  <= STG_GROUND;
        valid_q  <= '0;
      end
      if (cmd_i.begin_step) begin
        h_q     <= (stage_q == STG_BURNOUT);
        peak_q  <= peak_d;
        stage_q <= stage_d;
      end
      if (done) begin
        acc_q <= res;
        if (op_q == OP_EST) begin
          est_q[dst_q[1:0]] <= sat_narrow(res);
        end else begin
          valid_q[dst_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.begin_step) begin
      meas_q <= in_data_i.altitude;
    end
    if (cmd_i.fetch) begin
      code_a_q <= cmd_i.uop.a;
      code_b_q <= cmd_i.uop.b;
      ga_q     <= cmd_i.uop.ga;
      gb_q     <= cmd_i.uop.gb;
      spa_q    <= spec_val(cmd_i.uop.a);
      spb_q    <= spec_val(cmd_i.uop.b);
      vala_q   <= valid_q[cmd_i.uop.a[RF_AW-1:0]];
      valb_q   <= valid_q[cmd_i.uop.b[RF_AW-1:0]];
      op_q     <= cmd_i.uop.op;
      dst_q    <= cmd_i.uop.dst;
    end
    if (cmd_i.load_out) begin
      out_data_o.est_altitude     <= est_q[0];
      out_data_o.est_velocity     <= est_q[1];
      out_data_o.est_acceleration <= est_q[2];
      out_data_o.est_jerk         <= est_q[3];
      out_data_o.stage            <= stage_q;
    end
  end

endmodule

// ===== rtl/akst_ctrl.sv =====
// Controller: input/output handshake and the program sequencer.
// Depends on akst_pkg.
module akst_ctrl import akst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_kind_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output akst_cmd_t cmd_o,
  input  akst_sts_t sts_i
);

  localparam prog_t PROG = build_prog();

  ctrl_state_e     state_q;
  ctrl_state_e     state_d;
  logic [PC_W-1:0] pc_q;
  logic [PC_W-1:0] pc_d;
  logic            out_valid_q;
  logic            out_valid_d;
  logic            accept;
  logic            out_free;
  uop_t            uop;

  assign uop      = PROG[pc_q];
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pc_d    = '0;
          state_d = (in_kind_i == KIND_START) ? ST_DONE : ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = (uop.op == OP_END) ? ST_DONE : ST_ISSUE;
      end
      ST_ISSUE,
      ST_WAIT: begin
        if (sts_i.exec_done) begin
          pc_d    = pc_q + PC_W'(1);
          state_d = ST_FETCH;
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    cmd_o      = '0;
    cmd_o.uop  = uop;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_start = accept && (in_kind_i == KIND_START);
        cmd_o.begin_step = accept && (in_kind_i == KIND_SAMPLE);
      end
      ST_FETCH: cmd_o.fetch    = (uop.op != OP_END);
      ST_ISSUE: cmd_o.issue    = 1'b1;
      ST_DONE:  cmd_o.load_out = out_free;
      default: ;
    endcase
    out_valid_d = cmd_o.load_out || (out_valid_q && out_stall_i);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/altitude_kalman_stage_tracker.sv =====
// Top level of the four-state altitude Kalman tracker with flight staging.
// Depends on akst_pkg, akst_ctrl and akst_dp.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  in_data_i  (akst_in_t)
//   out      source     out_valid_o/out_stall_i  out_data_o (akst_out_t)
//   cfg      sink       cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item at a time. A start item runs no program; a sample item runs a
// 183-step program. Its run time is set by the shared 24x24 multiplier
// (85 products), the one-bit-per-cycle divider (8 quotients) and 90 adds.
// The result waits in an output register; the next item is taken meanwhile.
// Reset clears state and restores register defaults; no clearing pass.
module altitude_kalman_stage_tracker import akst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  akst_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output akst_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  akst_cmd_t cmd;
  akst_sts_t sts;

  assign cfg_ready_o = 1'b1;

  akst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_data_i.kind),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  akst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/akst_checker.sv =====
// Port-level checks for the altitude tracker, bound to the top level.
// Depends on akst_pkg.
module akst_checker import akst_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input akst_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input akst_out_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.kind == KIND_START) ##1 (!out_valid_o || !out_stall_i)
    |=> out_valid_o && out_data_o.est_altitude == $past(in_data_i.altitude, 2)
        && out_data_o.est_velocity == $past(in_data_i.start_velocity, 2)
        && out_data_o.est_acceleration == 32'sd0 && out_data_o.stage == STG_GROUND)
    else $error("start item result wrong");

  a_sample_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.kind == KIND_SAMPLE && !out_valid_o
    |=> !out_valid_o ##1 !out_valid_o)
    else $error("sample result too early");

endmodule

bind altitude_kalman_stage_tracker akst_checker u_akst_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking bench for the altitude Kalman stage tracker: directed and random
// items against a bit-exact predictor of the filter, with checks on every result.
// Depends on akst_pkg and altitude_kalman_stage_tracker.
module tb_top;
  import akst_pkg::*;

  localparam longint WIDE_MAX  = 64'sh7FFF_FFFF_FFFF;
  localparam longint WIDE_MIN  = -WIDE_MAX - 1;
  localparam longint NARROW_MAX = 64'sh7FFF_FFFF;
  localparam longint NARROW_MIN = -NARROW_MAX - 1;
  localparam int     IDLE_LIMIT = 20000;
  localparam int     LONG_HOLD  = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  akst_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  akst_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  altitude_kalman_stage_tracker uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // filter copy
  longint m_step_time, m_gravity, m_thresh, m_qa, m_qv, m_qc, m_qj, m_rn;
  longint m_est[4];
  longint m_cov[16];
  longint m_peak;
  stage_e m_stage;

  akst_out_t expected_track_q[$];
  int  err_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  burnout_seen = 0;
  int  apogee_seen = 0;
  bit  gaps_on = 1'b1;
  int  hold_req = 0;
  int  hold_ack = 0;
  int  rx_ack = 0;
  int  long_hold = 0;
  int  rx_wait = 0;
  int  idle_cnt = 0;

  function automatic longint sat48(longint v);
    if (v > WIDE_MAX) return WIDE_MAX;
    if (v < WIDE_MIN) return WIDE_MIN;
    return v;
  endfunction

  function automatic longint sat32(longint v);
    if (v > NARROW_MAX) return NARROW_MAX;
    if (v < NARROW_MIN) return NARROW_MIN;
    return v;
  endfunction

  function automatic bit [63:0] magn(longint v);
    return (v < 0) ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint clamp_mag(bit [63:0] m, bit neg);
    if (neg) begin
      if (m > 64'(WIDE_MAX) + 64'd1) m = 64'(WIDE_MAX) + 64'd1;
      return -longint'(m - 64'd1) - 1;
    end
    if (m > 64'(WIDE_MAX)) m = 64'(WIDE_MAX);
    return longint'(m);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    bit neg;
    bit [63:0] ua, ub, ah, al, bh, bl, hh, mid, ll;
    neg = (a < 0) != (b < 0);
    ua = magn(a);
    ub = magn(b);
    ah = ua >> 24;
    al = ua & 64'hFF_FFFF;
    bh = ub >> 24;
    bl = ub & 64'hFF_FFFF;
    hh = ah * bh;
    mid = ah * bl + al * bh;
    ll = al * bl;
    if (hh > (64'(WIDE_MAX) >> 32)) return clamp_mag(64'(WIDE_MAX) + 64'd1, neg);
    return clamp_mag((hh << 32) + (mid << 8) + (ll >> 16), neg);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    bit neg;
    bit [63:0] un, ud;
    neg = (n < 0) != (d < 0);
    un = magn(n);
    ud = magn(d);
    if (ud == 64'd0) return 0;
    return clamp_mag((un << 16) / ud, neg);
  endfunction

  function automatic void reset_filter();
    m_step_time = STEP_TIME_RST;
    m_gravity = GRAVITY_RST;
    m_thresh = THRESH_RST;
    m_qa = Q_ALT_RST;
    m_qv = Q_VEL_RST;
    m_qc = Q_ACC_RST;
    m_qj = Q_JERK_RST;
    m_rn = OBS_NOISE_RST;
    foreach (m_est[i]) m_est[i] = 0;
    foreach (m_cov[i]) m_cov[i] = 0;
    m_peak = 0;
    m_stage = STG_GROUND;
  endfunction

  function automatic void apply_config(logic [3:0] idx, logic [31:0] val);
    case (idx)
      CFG_STEP_TIME: m_step_time = val[15:0];
      CFG_GRAVITY:   m_gravity = val[30:0];
      CFG_THRESHOLD: m_thresh = val[30:0];
      CFG_Q_ALT:     m_qa = val[30:0];
      CFG_Q_VEL:     m_qv = val[30:0];
      CFG_Q_ACC:     m_qc = val[30:0];
      CFG_Q_JERK:    m_qj = val[30:0];
      CFG_OBS_NOISE: m_rn = val[30:0];
      default: ;
    endcase
  endfunction

  function automatic akst_out_t predict_track(akst_in_t it);
    akst_out_t o;
    longint x[4], xu[4], k0[4], k1[4], pu[16], t[16], qd[4];
    longint s00, s01, s10, s11, det, y0, y1, p0, p1, v;
    bit h;
    if (it.kind == KIND_START) begin
      m_est[0] = longint'(it.altitude);
      m_est[1] = longint'(it.start_velocity);
      m_est[2] = 0;
      m_est[3] = 0;
      foreach (m_cov[i]) m_cov[i] = 0;
      m_peak = 0;
      m_stage = STG_GROUND;
    end else begin
      h = (m_stage == STG_BURNOUT);
      x = m_est;
      if (x[2] > m_peak) m_peak = x[2];
      if (m_stage == STG_GROUND) begin
        if (m_peak > m_thresh && x[3] < 0) m_stage = STG_BURNOUT;
      end else if (m_stage == STG_BURNOUT) begin
        if (x[1] < 0) m_stage = STG_APOGEE;
      end
      s00 = sat48(m_cov[0] + m_rn);
      s01 = h ? m_cov[2] : 0;
      s10 = h ? m_cov[8] : 0;
      s11 = sat48((h ? m_cov[10] : 0) + m_rn);
      det = sat48(fx_mul(s00, s11) - fx_mul(s01, s10));
      for (int r = 0; r < 4; r++) begin
        p0 = m_cov[r*4];
        p1 = h ? m_cov[r*4+2] : 0;
        k0[r] = fx_div(sat48(fx_mul(p0, s11) - fx_mul(p1, s10)), det);
        k1[r] = fx_div(sat48(fx_mul(p1, s00) - fx_mul(p0, s01)), det);
      end
      y0 = sat48(longint'(it.altitude) - x[0]);
      y1 = h ? sat48(-m_gravity - x[2]) : 0;
      for (int r = 0; r < 4; r++)
        xu[r] = sat48(x[r] + fx_mul(k0[r], y0) + fx_mul(k1[r], y1));
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          pu[r*4+c] = sat48(m_cov[r*4+c] - fx_mul(k0[r], m_cov[c])
                            - (h ? fx_mul(k1[r], m_cov[8+c]) : 0));
      for (int r = 0; r < 3; r++) x[r] = sat48(xu[r] + fx_mul(m_step_time, xu[r+1]));
      x[3] = xu[3];
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          t[r*4+c] = (r < 3) ? sat48(pu[r*4+c] + fx_mul(m_step_time, pu[(r+1)*4+c]))
                             : pu[r*4+c];
      qd[0] = m_qa;
      qd[1] = m_qv;
      qd[2] = m_qc;
      qd[3] = m_qj;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          v = t[r*4+c];
          if (c < 3) v = sat48(v + fx_mul(m_step_time, t[r*4+c+1]));
          if (r == c) v = sat48(v + qd[r]);
          m_cov[r*4+c] = v;
        end
      for (int r = 0; r < 4; r++) m_est[r] = sat32(x[r]);
    end
    o.est_altitude = m_est[0][31:0];
    o.est_velocity = m_est[1][31:0];
    o.est_acceleration = m_est[2][31:0];
    o.est_jerk = m_est[3][31:0];
    o.stage = m_stage;
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d, %s: got %h, expected %h", results_seen, field, got,
             want);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    akst_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_track_q.size() == 0) begin
        report_mismatch("unexpected item", 32'd0, 32'd0);
      end else begin
        e = expected_track_q.pop_front();
        if (out_data.est_altitude !== e.est_altitude)
          report_mismatch("est_altitude", out_data.est_altitude, e.est_altitude);
        if (out_data.est_velocity !== e.est_velocity)
          report_mismatch("est_velocity", out_data.est_velocity, e.est_velocity);
        if (out_data.est_acceleration !== e.est_acceleration)
          report_mismatch("est_acceleration", out_data.est_acceleration,
                          e.est_acceleration);
        if (out_data.est_jerk !== e.est_jerk)
          report_mismatch("est_jerk", out_data.est_jerk, e.est_jerk);
        if (out_data.stage !== e.stage)
          report_mismatch("stage", 32'(out_data.stage), 32'(e.stage));
        if (e.stage == STG_BURNOUT) burnout_seen++;
        if (e.stage == STG_APOGEE) apogee_seen++;
      end
      results_seen++;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      long_hold = LONG_HOLD;
    end
    if (results_seen != rx_ack) begin
      rx_ack = results_seen;
      rx_wait = gaps_on ? $urandom_range(0, 14) : 0;
    end
    if (long_hold > 0) begin
      out_stall <= 1'b1;
      long_hold--;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cnt = 0;
      else
        idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_item(akst_in_t it);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    expected_track_q.push_back(predict_track(it));
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_track_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_config(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic akst_in_t mk_item(logic kind, logic [31:0] alt, logic [31:0] vel);
    akst_in_t it;
    it.kind = kind;
    it.altitude = alt;
    it.start_velocity = vel;
    return it;
  endfunction

  task automatic send_flight(int n);
    longint a0, v, c, alt;
    a0 = longint'($signed($urandom_range(0, 4000))) <<< 16;
    v = $urandom_range(0, 3000);
    c = $urandom_range(0, 40);
    send_item(mk_item(KIND_START, a0[31:0], 32'($urandom_range(0, 65536 * 50))));
    for (int k = 1; k <= n; k++) begin
      alt = sat32(a0 + v * k * 64 - c * k * k * 16 + $signed($urandom_range(0, 4096)) - 2048);
      send_item(mk_item(KIND_SAMPLE, alt[31:0], $urandom));
    end
  endtask

  task automatic test_reset_state();
    send_item(mk_item(KIND_SAMPLE, 32'h0001_0000, $urandom));
    send_item(mk_item(KIND_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000));
  endtask

  task automatic test_field_extremes();
    send_item(mk_item(KIND_START, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(mk_item(KIND_SAMPLE, 32'h8000_0000, 32'h0));
    send_item(mk_item(KIND_START, 32'h8000_0000, 32'h8000_0000));
    send_item(mk_item(KIND_SAMPLE, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_item(KIND_SAMPLE, 32'h7FFF_FFFF, 32'h0));
    send_item(mk_item(KIND_START, 32'h0, 32'h0));
    send_item(mk_item(KIND_SAMPLE, 32'hFFFF_FFFF, 32'h1234_5678));
  endtask

  task automatic test_zero_determinant();
    write_reg(CFG_OBS_NOISE, 32'd1);
    send_item(mk_item(KIND_START, 32'h0010_0000, 32'h0));
    send_item(mk_item(KIND_SAMPLE, 32'h0020_0000, 32'h0));
    send_item(mk_item(KIND_SAMPLE, 32'h7FFF_0000, 32'h0));
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_STEP_TIME, 32'hFFFF_FFFF);
    write_reg(CFG_GRAVITY, 32'hFFFF_FFFF);
    write_reg(CFG_THRESHOLD, 32'd0);
    write_reg(CFG_Q_ALT, 32'h7FFF_FFFF);
    write_reg(CFG_Q_VEL, 32'h7FFF_FFFF);
    write_reg(CFG_Q_ACC, 32'd0);
    write_reg(CFG_Q_JERK, 32'h7FFF_FFFF);
    write_reg(CFG_OBS_NOISE, 32'h7FFF_FFFF);
    write_reg(4'd9, $urandom);
    write_reg(4'd15, $urandom);
    send_item(mk_item(KIND_START, 32'h0100_0000, 32'h0010_0000));
    repeat (4) send_item(mk_item(KIND_SAMPLE, $urandom, $urandom));
    write_reg(CFG_STEP_TIME, 32'd1);
    write_reg(CFG_Q_ALT, 32'd0);
    write_reg(CFG_Q_VEL, 32'd0);
    write_reg(CFG_Q_JERK, 32'd0);
    write_reg(CFG_GRAVITY, 32'd0);
    write_reg(CFG_THRESHOLD, 32'h7FFF_FFFF);
    send_item(mk_item(KIND_START, 32'h0, 32'h0));
    repeat (3) send_item(mk_item(KIND_SAMPLE, $urandom, $urandom));
  endtask

  task automatic randomise_registers();
    write_reg(CFG_STEP_TIME, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 6000));
    write_reg(CFG_GRAVITY, ($urandom_range(0, 3) == 0) ? $urandom : 32'(642908));
    write_reg(CFG_THRESHOLD, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536));
    write_reg(CFG_Q_ALT, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 70000));
    write_reg(CFG_Q_VEL, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 70000));
    write_reg(CFG_Q_ACC, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 70000));
    write_reg(CFG_Q_JERK, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 7000));
    write_reg(CFG_OBS_NOISE, $urandom_range(0, 3) == 0 ? $urandom | 32'd1
                                                    : $urandom_range(1, 8000000));
  endtask

  task automatic test_random_flights();
    for (int ph = 0; ph < 24; ph++) begin
      gaps_on = (ph % 5 != 2);
      randomise_registers();
      for (int f = 0; f < 2; f++) send_flight($urandom_range(20, 45));
      repeat ($urandom_range(2, 6))
        send_item(mk_item($urandom_range(0, 7) == 0 ? KIND_START : KIND_SAMPLE,
                          $urandom, $urandom));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_back_pressure();
    drain();
    gaps_on = 1'b0;
    hold_req++;
    send_item(mk_item(KIND_START, 32'h0040_0000, 32'h0008_0000));
    repeat (8) send_item(mk_item(KIND_SAMPLE, $urandom, $urandom));
    gaps_on = 1'b1;
    drain();
  endtask

  initial begin
    reset_filter();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_field_extremes();
    test_zero_determinant();
    test_register_extremes();
    test_back_pressure();
    test_random_flights();
    drain();
    repeat (2000) @(posedge clk);
    $display("sent %0d items, checked %0d results", items_sent, results_seen);
    $display("results in burnout: %0d, in apogee: %0d", burnout_seen, apogee_seen);
    if (err_count == 0 && expected_track_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/akst_pkg.sv
rtl/akst_ram.sv
rtl/akst_muldiv.sv
rtl/akst_dp.sv
rtl/akst_ctrl.sv
rtl/altitude_kalman_stage_tracker.sv
rtl/akst_checker.sv
sim/tb_top.sv
